[hw/rtl/ccr_pkg.sv]
// Shared types and constants for the drive-command current ramp block.
// Holds fixed-point widths, register indexes, drive action codes and float limits.
// No dependencies.
package ccr_pkg;

    localparam int CURRENT_FRAC_BITS = 8;

    typedef logic signed [19:0] current_t;
    typedef logic signed [18:0] setpoint_t;
    typedef logic [2:0]         cfg_index_t;
    typedef logic [17:0]        cfg_data_t;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_SET     = 2'd2
    } action_t;

    localparam cfg_index_t CFG_BASE_ID        = 3'd0;
    localparam cfg_index_t CFG_GT_MODE        = 3'd1;
    localparam cfg_index_t CFG_PROTOCOL_ON    = 3'd2;
    localparam cfg_index_t CFG_CURRENT_MAX    = 3'd3;
    localparam cfg_index_t CFG_FAN_ON_TEMP    = 3'd4;
    localparam cfg_index_t CFG_FAN_HYSTERESIS = 3'd5;

    localparam logic signed [12:0] CMD_OFFSET = 13'sh100;
    localparam logic signed [12:0] DRIVE_ID   = 13'sh001;

    localparam logic [31:0] FRAC_MIN_BITS = 32'h3C23D70B;
    localparam logic [31:0] ONE_BITS      = 32'h3F800000;
    localparam logic [31:0] INF_BITS      = 32'h7F800000;

    localparam current_t RAMP_STEP = current_t'(2 << CURRENT_FRAC_BITS);
    localparam current_t ONE_AMP   = current_t'(1 << CURRENT_FRAC_BITS);

    localparam logic [10:0]       RST_BASE_ID        = 11'd0;
    localparam logic              RST_GT_MODE        = 1'b1;
    localparam logic              RST_PROTOCOL_ON    = 1'b0;
    localparam logic [17:0]       RST_CURRENT_MAX    = 18'd0;
    localparam logic signed [8:0] RST_FAN_ON_TEMP    = 9'sd80;
    localparam logic [5:0]        RST_FAN_HYSTERESIS = 6'd10;

endpackage

[hw/rtl/can_drive_current_ramp.sv]
// Drive-command receiver: frame decode, float-to-current conversion, current ramp, fan flag.
// Depends on ccr_pkg.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------------
//  in       | in_valid / in_ready    | cmd, frame_id, velocity_word, current_word, fet_temp
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//  out      | out_valid / out_ready  | frame_accepted, drive_action, current_setpoint, fan_on
//
// One item per cycle while out_ready takes the results; an input register, then a result register.
// The 24x18 fraction multiply and the ramp step sit between those two registers.
// Reset clears configuration to its defaults, commanded and ramped current to zero, fan off.
// A stalled result holds the result register; the input register still takes one more item.
// cfg_ready is always high.
module can_drive_current_ramp
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  cmd,
    input  logic [10:0]           frame_id,
    input  logic [31:0]           velocity_word,
    input  logic [31:0]           current_word,
    input  logic signed [8:0]     fet_temp,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  ccr_pkg::cfg_index_t   cfg_index,
    input  ccr_pkg::cfg_data_t    cfg_data,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  frame_accepted,
    output logic [1:0]            drive_action,
    output ccr_pkg::setpoint_t    current_setpoint,
    output logic                  fan_on
);

    logic [10:0]       base_id_reg;
    logic              gt_mode_reg;
    logic              protocol_on_reg;
    logic [17:0]       current_max_reg;
    logic signed [8:0] fan_on_temp_reg;
    logic [5:0]        fan_hysteresis_reg;

    ccr_pkg::current_t commanded_reg;
    ccr_pkg::current_t commanded_next;
    ccr_pkg::current_t ramped_reg;
    ccr_pkg::current_t ramped_next;
    logic              fan_state_reg;
    logic              fan_state_next;

    logic              s1_valid_reg;
    logic              s1_cmd_reg;
    logic [10:0]       s1_frame_id_reg;
    logic [31:0]       s1_velocity_reg;
    logic [31:0]       s1_current_reg;
    logic signed [8:0] s1_temp_reg;

    logic                 out_valid_reg;
    logic                 accepted_reg;
    logic                 accepted_next;
    ccr_pkg::action_t     action_reg;
    ccr_pkg::action_t     action_next;
    ccr_pkg::setpoint_t   setpoint_reg;
    ccr_pkg::setpoint_t   setpoint_next;

    logic s1_advance;
    logic in_fire;

    logic signed [12:0] target_id;
    logic               id_match;
    logic               frac_ok;
    logic               vel_positive;
    logic [2:0]         exp_k;
    logic [23:0]        mantissa;
    logic [41:0]        product;
    logic [41:0]        product_shifted;
    logic [20:0]        round_sum;
    ccr_pkg::current_t  magnitude;
    ccr_pkg::current_t  converted;

    logic signed [20:0] delta_raw;
    logic signed [20:0] delta_clamped;
    logic               release_zone;

    logic signed [9:0]  temp_ext;
    logic signed [9:0]  on_temp_ext;
    logic signed [9:0]  off_temp;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;
    assign cfg_ready  = 1'b1;

    // Frame decode and command conversion
    assign target_id = $signed({2'b00, base_id_reg})
                     + (gt_mode_reg ? ccr_pkg::CMD_OFFSET : -ccr_pkg::CMD_OFFSET)
                     + ccr_pkg::DRIVE_ID;
    assign id_match  = (target_id == $signed({2'b00, s1_frame_id_reg}));

    assign frac_ok      = (s1_current_reg >= ccr_pkg::FRAC_MIN_BITS)
                       && (s1_current_reg <= ccr_pkg::ONE_BITS);
    assign vel_positive = (s1_velocity_reg > ccr_pkg::ONE_BITS)
                       && (s1_velocity_reg <= ccr_pkg::INF_BITS);

    // Exponent 120..127 maps to an extra shift of 7..0
    assign exp_k           = ~s1_current_reg[25:23];
    assign mantissa        = {1'b1, s1_current_reg[22:0]};
    assign product         = 42'(mantissa) * 42'(current_max_reg);
    assign product_shifted = product >> (6'd22 + 6'(exp_k));
    assign round_sum       = {1'b0, product_shifted[19:0]} + 21'd1;
    assign magnitude       = ccr_pkg::current_t'(round_sum[20:1]);

    always_comb
    begin
        if (!frac_ok)
        begin
            converted = '0;
        end
        else if (vel_positive)
        begin
            converted = magnitude;
        end
        else
        begin
            converted = -magnitude;
        end
    end

    // Ramp and fan
    assign delta_raw = {commanded_reg[19], commanded_reg} - {ramped_reg[19], ramped_reg};

    always_comb
    begin
        if (delta_raw > 21'(ccr_pkg::RAMP_STEP))
        begin
            delta_clamped = 21'(ccr_pkg::RAMP_STEP);
        end
        else if (delta_raw < -21'(ccr_pkg::RAMP_STEP))
        begin
            delta_clamped = -21'(ccr_pkg::RAMP_STEP);
        end
        else
        begin
            delta_clamped = delta_raw;
        end
    end

    assign temp_ext    = {s1_temp_reg[8], s1_temp_reg};
    assign on_temp_ext = {fan_on_temp_reg[8], fan_on_temp_reg};
    assign off_temp    = on_temp_ext - $signed({4'b0000, fan_hysteresis_reg});

    always_comb
    begin
        commanded_next = commanded_reg;
        ramped_next    = ramped_reg;
        fan_state_next = fan_state_reg;
        accepted_next  = 1'b0;
        action_next    = ccr_pkg::ACT_NONE;
        setpoint_next  = '0;
        release_zone   = 1'b0;
        if (protocol_on_reg)
        begin
            if (!s1_cmd_reg)
            begin
                if (id_match)
                begin
                    commanded_next = converted;
                    accepted_next  = 1'b1;
                end
            end
            else
            begin
                ramped_next  = ramped_reg + delta_clamped[19:0];
                release_zone = (ramped_next < ccr_pkg::ONE_AMP)
                            && (ramped_next > -ccr_pkg::ONE_AMP);
                if (release_zone)
                begin
                    action_next = ccr_pkg::ACT_RELEASE;
                end
                else
                begin
                    action_next   = ccr_pkg::ACT_SET;
                    setpoint_next = ramped_next[18:0];
                end
                if (temp_ext >= on_temp_ext)
                begin
                    fan_state_next = 1'b1;
                end
                else if (temp_ext <= off_temp)
                begin
                    fan_state_next = 1'b0;
                end
            end
        end
    end

    // Control, configuration and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_id_reg        <= ccr_pkg::RST_BASE_ID;
            gt_mode_reg        <= ccr_pkg::RST_GT_MODE;
            protocol_on_reg    <= ccr_pkg::RST_PROTOCOL_ON;
            current_max_reg    <= ccr_pkg::RST_CURRENT_MAX;
            fan_on_temp_reg    <= ccr_pkg::RST_FAN_ON_TEMP;
            fan_hysteresis_reg <= ccr_pkg::RST_FAN_HYSTERESIS;
            commanded_reg      <= '0;
            ramped_reg         <= '0;
            fan_state_reg      <= 1'b0;
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    ccr_pkg::CFG_BASE_ID:        base_id_reg        <= cfg_data[10:0];
                    ccr_pkg::CFG_GT_MODE:        gt_mode_reg        <= cfg_data[0];
                    ccr_pkg::CFG_PROTOCOL_ON:    protocol_on_reg    <= cfg_data[0];
                    ccr_pkg::CFG_CURRENT_MAX:    current_max_reg    <= cfg_data[17:0];
                    ccr_pkg::CFG_FAN_ON_TEMP:    fan_on_temp_reg    <= $signed(cfg_data[8:0]);
                    ccr_pkg::CFG_FAN_HYSTERESIS: fan_hysteresis_reg <= cfg_data[5:0];
                    default:                     ;
                endcase
            end
            if (s1_advance)
            begin
                commanded_reg <= commanded_next;
                ramped_reg    <= ramped_next;
                fan_state_reg <= fan_state_next;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg      <= cmd;
            s1_frame_id_reg <= frame_id;
            s1_velocity_reg <= velocity_word;
            s1_current_reg  <= current_word;
            s1_temp_reg     <= fet_temp;
        end
        if (s1_advance)
        begin
            accepted_reg <= accepted_next;
            action_reg   <= action_next;
            setpoint_reg <= setpoint_next;
        end
    end

    logic fan_out_reg;

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            fan_out_reg <= fan_state_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign frame_accepted   = accepted_reg;
    assign drive_action     = action_reg;
    assign current_setpoint = setpoint_reg;
    assign fan_on           = fan_out_reg;

    a_frame_no_action: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_accepted) |-> (drive_action == ccr_pkg::ACT_NONE))
        else $error("accepted frame carries a drive action");

    a_setpoint_only_on_set: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (drive_action != ccr_pkg::ACT_SET)) |-> (current_setpoint == '0))
        else $error("nonzero setpoint without set action");

    a_ramp_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((21'(ramped_reg) - 21'($past(ramped_reg)) <= 21'(ccr_pkg::RAMP_STEP))
               && (21'(ramped_reg) - 21'($past(ramped_reg)) >= -21'(ccr_pkg::RAMP_STEP))))
        else $error("ramped current moved more than one step");

    a_state_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_advance |=> $stable(commanded_reg) && $stable(ramped_reg) && $stable(fan_state_reg))
        else $error("state changed without an item advancing");

endmodule

[tb/can_drive_current_ramp_tb.sv]
`timescale 1ns / 1ps
// Testbench for can_drive_current_ramp: drive-frame decode, current ramp and fan hysteresis.
// Predicts every result with a local model of the block and checks it field by field.
// Depends on ccr_pkg and can_drive_current_ramp.
module can_drive_current_ramp_tb;

    localparam logic CMD_FRAME      = 1'b0;
    localparam logic CMD_TICK       = 1'b1;
    localparam int   HOLD_CYCLES    = 300;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   END_PAUSE      = 8;
    localparam int   MAX_REPORTS    = 40;

    typedef struct packed {
        logic               accepted;
        ccr_pkg::action_t   action;
        ccr_pkg::setpoint_t setpoint;
        logic               fan;
    } drive_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 cmd = 1'b0;
    logic [10:0]          frame_id = '0;
    logic [31:0]          velocity_word = '0;
    logic [31:0]          current_word = '0;
    logic signed [8:0]    fet_temp = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    ccr_pkg::cfg_index_t  cfg_index = ccr_pkg::CFG_BASE_ID;
    ccr_pkg::cfg_data_t   cfg_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 frame_accepted;
    logic [1:0]           drive_action;
    ccr_pkg::setpoint_t   current_setpoint;
    logic                 fan_on;

    logic [10:0]          shadow_base = ccr_pkg::RST_BASE_ID;
    logic                 shadow_gt = ccr_pkg::RST_GT_MODE;
    logic                 shadow_proto = ccr_pkg::RST_PROTOCOL_ON;
    logic [17:0]          shadow_imax = ccr_pkg::RST_CURRENT_MAX;
    logic signed [8:0]    shadow_fan_on = ccr_pkg::RST_FAN_ON_TEMP;
    logic [5:0]           shadow_fan_hyst = ccr_pkg::RST_FAN_HYSTERESIS;
    ccr_pkg::current_t    pred_cmd_current = '0;
    ccr_pkg::current_t    pred_ramp = '0;
    logic                 pred_fan = 1'b0;

    drive_result_t     expected_drive_q[$];
    int                mismatches = 0;
    int                idle_pct = 6;
    logic              hold_req = 1'b0;
    int                stall_left = 0;
    int                quiet_cycles = 0;

    can_drive_current_ramp dut (.*);

    always #1 clk = ~clk;

    function automatic ccr_pkg::current_t fraction_to_current(logic [31:0] vw,
                                                              logic [31:0] cw,
                                                              logic [17:0] imax);
        logic [23:0]       mant;
        logic [47:0]       prod;
        int                sh;
        ccr_pkg::current_t mag;
        if (cw < ccr_pkg::FRAC_MIN_BITS || cw > ccr_pkg::ONE_BITS)
            return '0;
        mant = {1'b1, cw[22:0]};
        sh = 150 - int'(cw[30:23]);
        prod = mant * imax;
        prod = prod + (48'd1 << (sh - 1));
        mag = ccr_pkg::current_t'(prod >> sh);
        return (vw > ccr_pkg::ONE_BITS && vw <= ccr_pkg::INF_BITS) ? mag : -mag;
    endfunction

    task automatic drive_model_step(input logic op, input logic [10:0] id,
                                    input logic [31:0] vw, input logic [31:0] cw,
                                    input logic signed [8:0] temp,
                                    output drive_result_t r);
        int target;
        int delta;
        int t;
        int on_t;
        r.accepted = 1'b0;
        r.action = ccr_pkg::ACT_NONE;
        r.setpoint = '0;
        if (shadow_proto)
        begin
            if (op == CMD_FRAME)
            begin
                target = int'(shadow_base)
                         + (shadow_gt ? int'(ccr_pkg::CMD_OFFSET) : -int'(ccr_pkg::CMD_OFFSET))
                         + int'(ccr_pkg::DRIVE_ID);
                if (target == int'(id))
                begin
                    pred_cmd_current = fraction_to_current(vw, cw, shadow_imax);
                    r.accepted = 1'b1;
                end
            end
            else
            begin
                delta = int'(pred_cmd_current) - int'(pred_ramp);
                if (delta > int'(ccr_pkg::RAMP_STEP))
                    delta = int'(ccr_pkg::RAMP_STEP);
                else if (delta < -int'(ccr_pkg::RAMP_STEP))
                    delta = -int'(ccr_pkg::RAMP_STEP);
                pred_ramp = ccr_pkg::current_t'(int'(pred_ramp) + delta);
                if (pred_ramp < ccr_pkg::ONE_AMP && pred_ramp > -ccr_pkg::ONE_AMP)
                    r.action = ccr_pkg::ACT_RELEASE;
                else
                begin
                    r.action = ccr_pkg::ACT_SET;
                    r.setpoint = ccr_pkg::setpoint_t'(pred_ramp);
                end
                t = int'(temp);
                on_t = int'(shadow_fan_on);
                if (t >= on_t)
                    pred_fan = 1'b1;
                else if (t <= on_t - int'(shadow_fan_hyst))
                    pred_fan = 1'b0;
            end
        end
        r.fan = pred_fan;
    endtask

    task automatic flag_field(input string name, input int want, input int got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    endtask

    always @(posedge clk)
    begin : check_results
        drive_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_drive_q.size() == 0)
                flag_field("unexpected result, queue depth", 0, 1);
            else
            begin
                want = expected_drive_q.pop_front();
                if (frame_accepted !== want.accepted)
                    flag_field("frame_accepted", want.accepted, frame_accepted);
                if (drive_action !== want.action)
                    flag_field("drive_action", want.action, drive_action);
                if (current_setpoint !== want.setpoint)
                    flag_field("current_setpoint", want.setpoint, current_setpoint);
                if (fan_on !== want.fan)
                    flag_field("fan_on", want.fan, fan_on);
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_req)
            stall_left = HOLD_CYCLES;
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_item(input logic op, input logic [10:0] id, input logic [31:0] vw,
                             input logic [31:0] cw, input logic signed [8:0] temp);
        drive_result_t want;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        frame_id <= id;
        velocity_word <= vw;
        current_word <= cw;
        fet_temp <= temp;
        do
            @(posedge clk);
        while (!in_ready);
        drive_model_step(op, id, vw, cw, temp, want);
        expected_drive_q.push_back(want);
    endtask

    task automatic finish_stream();
        in_valid <= 1'b0;
        while (expected_drive_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input ccr_pkg::cfg_index_t idx, input ccr_pkg::cfg_data_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            ccr_pkg::CFG_BASE_ID:        shadow_base = data[10:0];
            ccr_pkg::CFG_GT_MODE:        shadow_gt = data[0];
            ccr_pkg::CFG_PROTOCOL_ON:    shadow_proto = data[0];
            ccr_pkg::CFG_CURRENT_MAX:    shadow_imax = data[17:0];
            ccr_pkg::CFG_FAN_ON_TEMP:    shadow_fan_on = data[8:0];
            ccr_pkg::CFG_FAN_HYSTERESIS: shadow_fan_hyst = data[5:0];
            default:                     ;
        endcase
    endtask

    // Unused upper data bits carry junk; the block keeps only the register's width.
    task automatic configure(input int base, input logic gt, input logic proto, input int imax,
                             input int on_temp, input int hyst);
        logic [31:0] junk;
        finish_stream();
        junk = $urandom;
        write_reg(ccr_pkg::CFG_BASE_ID, {junk[6:0], base[10:0]});
        write_reg(ccr_pkg::CFG_GT_MODE, {junk[16:0], gt});
        write_reg(ccr_pkg::CFG_PROTOCOL_ON, {junk[17:1], proto});
        write_reg(ccr_pkg::CFG_CURRENT_MAX, imax[17:0]);
        write_reg(ccr_pkg::CFG_FAN_ON_TEMP, {junk[8:0], on_temp[8:0]});
        write_reg(ccr_pkg::CFG_FAN_HYSTERESIS, {junk[11:0], hyst[5:0]});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_item(input int target);
        int          pick;
        int          t;
        logic [31:0] vw;
        logic [31:0] cw;
        logic [10:0] id;
        pick = $urandom_range(99);
        t = $urandom_range(0, 250);
        t = t - 50;
        if (pick < 45)
        begin
            if ($urandom_range(1))
            begin
                t = int'(shadow_fan_on) + 2;
                pick = $urandom_range(0, int'(shadow_fan_hyst) + 5);
                t = t - pick;
                if (t < -50)
                    t = -50;
                if (t > 200)
                    t = 200;
            end
            send_item(CMD_TICK, 11'($urandom), $urandom, $urandom, 9'(t));
        end
        else if (pick < 85)
        begin
            cw = $urandom_range(ccr_pkg::FRAC_MIN_BITS, ccr_pkg::ONE_BITS);
            if ($urandom_range(9) == 0)
                case ($urandom_range(7))
                    0: cw = ccr_pkg::FRAC_MIN_BITS;
                    1: cw = ccr_pkg::ONE_BITS;
                    2: cw = ccr_pkg::FRAC_MIN_BITS - 1;
                    3: cw = ccr_pkg::ONE_BITS + 1;
                    4: cw = 32'h8000_0000;
                    5: cw = ccr_pkg::INF_BITS;
                    6: cw = 32'h7FC0_0000;
                    default: cw = 32'h3F00_0000;
                endcase
            vw = $urandom_range(1) ? $urandom_range(ccr_pkg::ONE_BITS + 1, ccr_pkg::INF_BITS)
                                   : $urandom;
            send_item(CMD_FRAME, 11'(target), vw, cw, 9'(t));
        end
        else
        begin
            case ($urandom_range(2))
                0: id = 11'($urandom);
                1: id = 11'(target + 1);
                default: id = 11'(target - 1);
            endcase
            send_item(CMD_FRAME, id, $urandom, $urandom, 9'(t));
        end
    endtask

    task automatic test_protocol_off();
        send_item(CMD_FRAME, 11'h101, ccr_pkg::INF_BITS, ccr_pkg::ONE_BITS, 9'sd25);
        send_item(CMD_TICK, 11'h000, '0, '0, 9'sd200);
        send_item(CMD_TICK, 11'h101, ccr_pkg::INF_BITS, ccr_pkg::ONE_BITS, -9'sd50);
        finish_stream();
    endtask

    task automatic test_frame_decode();
        configure(32'h020, 1'b1, 1'b1, 262143, 80, 10);
        send_item(CMD_FRAME, 11'h121, 32'h3F80_0001, ccr_pkg::ONE_BITS, 9'sd25);
        send_item(CMD_TICK, 11'h000, '0, '0, 9'sd79);
        send_item(CMD_FRAME, 11'h120, ccr_pkg::INF_BITS, ccr_pkg::ONE_BITS, 9'sd25);
        send_item(CMD_FRAME, 11'h121, ccr_pkg::ONE_BITS, ccr_pkg::FRAC_MIN_BITS, 9'sd25);
        send_item(CMD_TICK, 11'h000, '0, '0, 9'sd80);
        send_item(CMD_TICK, 11'h000, '0, '0, 9'sd71);
        send_item(CMD_FRAME, 11'h121, ccr_pkg::INF_BITS, ccr_pkg::FRAC_MIN_BITS - 1, 9'sd0);
        send_item(CMD_FRAME, 11'h121, ccr_pkg::INF_BITS, ccr_pkg::ONE_BITS + 1, 9'sd0);
        send_item(CMD_FRAME, 11'h121, 32'hFF80_0000, 32'h8000_0000, 9'sd0);
        send_item(CMD_FRAME, 11'h121, ccr_pkg::INF_BITS, ccr_pkg::INF_BITS, 9'sd0);
        send_item(CMD_FRAME, 11'h121, ccr_pkg::INF_BITS, 32'h7FC0_0000, 9'sd0);
        send_item(CMD_FRAME, 11'h121, 32'h7FC0_0000, 32'h3F00_0000, 9'sd0);
        send_item(CMD_TICK, 11'h000, '0, '0, 9'sd70);
        send_item(CMD_FRAME, 11'h121, 32'h7F80_0001, 32'h3DCC_CCCD, 9'sd0);
        send_item(CMD_FRAME, 11'h121, ccr_pkg::INF_BITS, 32'h3DCC_CCCD, 9'sd0);
        send_item(CMD_TICK, 11'h000, '0, '0, 9'sd200);
        finish_stream();
    endtask

    task automatic test_unreachable_base();
        configure(32'h050, 1'b0, 1'b1, 1000, 80, 10);
        send_item(CMD_FRAME, 11'h751, ccr_pkg::INF_BITS, ccr_pkg::ONE_BITS, 9'sd20);
        configure(32'h7FF, 1'b1, 1'b1, 1000, 80, 10);
        send_item(CMD_FRAME, 11'h100, ccr_pkg::INF_BITS, ccr_pkg::ONE_BITS, 9'sd20);
        configure(32'h7FF, 1'b0, 1'b1, 1000, 80, 10);
        send_item(CMD_FRAME, 11'h700, ccr_pkg::INF_BITS, ccr_pkg::ONE_BITS, 9'sd20);
        send_item(CMD_TICK, 11'h000, '0, '0, 9'sd20);
        finish_stream();
    endtask

    task automatic test_fan_extremes();
        configure(32'h000, 1'b1, 1'b1, 0, -50, 0);
        send_item(CMD_TICK, 11'h000, '0, '0, -9'sd50);
        configure(32'h000, 1'b1, 1'b1, 0, 200, 50);
        send_item(CMD_TICK, 11'h000, '0, '0, 9'sd199);
        send_item(CMD_TICK, 11'h000, '0, '0, 9'sd150);
        send_item(CMD_TICK, 11'h000, '0, '0, 9'sd200);
        finish_stream();
    endtask

    task automatic test_random_phases();
        int   base;
        logic gt;
        logic proto;
        int   imax;
        int   on_temp;
        int   hyst;
        int   count;
        for (int ph = 0; ph < 6; ph++)
        begin
            gt = $urandom_range(1);
            base = gt ? $urandom_range(0, 32'h6FE) : $urandom_range(32'h0FF, 32'h7FF);
            imax = ($urandom_range(3) == 0) ? $urandom_range(0, 262143) : $urandom_range(0, 8191);
            on_temp = $urandom_range(0, 250);
            on_temp = on_temp - 50;
            hyst = $urandom_range(0, 50);
            proto = 1'b1;
            count = 115;
            case (ph)
                0:
                begin
                    gt = 1'b1;
                    base = 32'h6FE;
                    imax = 262143;
                    on_temp = 200;
                    hyst = 50;
                end
                1:
                begin
                    gt = 1'b0;
                    base = 32'h0FF;
                    imax = 0;
                    on_temp = -50;
                    hyst = 0;
                end
                2:
                begin
                    proto = 1'b0;
                    count = 30;
                end
                default: ;
            endcase
            configure(base, gt, proto, imax, on_temp, hyst);
            idle_pct = (ph == 3) ? 0 : 6;
            for (int n = 0; n < count; n++)
                send_random_item(base + (gt ? 256 : -256) + 1);
            finish_stream();
        end
        idle_pct = 6;
    endtask

    // Hold the result side long enough for the block to stall its input.
    task automatic test_output_stall();
        configure(32'h200, 1'b1, 1'b1, 4000, 60, 5);
        idle_pct = 0;
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        for (int n = 0; n < 20; n++)
            send_random_item(32'h301);
        finish_stream();
        idle_pct = 6;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_protocol_off();
        test_frame_decode();
        test_unreachable_base();
        test_fan_extremes();
        test_random_phases();
        test_output_stall();
        finish_stream();
        repeat (END_PAUSE) @(posedge clk);
        if (expected_drive_q.size() != 0)
            flag_field("leftover results", 0, expected_drive_q.size());
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
